// ===== hw/rtl/rva_pkg.sv =====
// Shared constants, command/status codes and controller-datapath structs
// for the running variance accumulator. No dependencies.
package rva_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int COUNT_BITS    = 12;
    localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_BITS       = 2 * SAMPLE_BITS + COUNT_BITS - 1;
    localparam int SQR_BITS      = 2 * SAMPLE_BITS - 1;
    localparam int NUM_BITS      = COUNT_BITS + SQ_BITS;
    localparam int DEN_BITS      = 2 * COUNT_BITS;
    localparam int BIASED_BITS   = 2 * SAMPLE_BITS - 1;
    localparam int UNBIASED_BITS = 2 * SAMPLE_BITS;
    localparam int DIV_CNT_BITS  = $clog2(NUM_BITS);

    // port widths from the interface definition
    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic do_square;
        logic do_update;
        logic do_mult;
        logic do_prep;
        logic do_step;
        logic load_out;
    } rva_cmd_t;

    typedef struct packed {
        logic out_free;
    } rva_stat_t;

endpackage

// ===== hw/rtl/rva_div.sv =====
// Bit-serial restoring divider, one quotient bit per step.
// Depends on rva_pkg for NUM_BITS and DEN_BITS.
module rva_div
(
    input  logic                          clk,
    input  logic                          load,
    input  logic                          step,
    input  logic [rva_pkg::NUM_BITS-1:0]  dividend,
    input  logic [rva_pkg::DEN_BITS-1:0]  divisor,
    output logic [rva_pkg::NUM_BITS-1:0]  quotient
);

    logic [rva_pkg::NUM_BITS-1:0] q_reg;
    logic [rva_pkg::DEN_BITS-1:0] rem_reg;
    logic [rva_pkg::DEN_BITS-1:0] den_reg;
    logic [rva_pkg::DEN_BITS:0]   rem_shift;
    logic [rva_pkg::DEN_BITS:0]   rem_sub;
    logic                         fits;

    // dividend shifts out of the quotient register MSB first
    assign rem_shift = {rem_reg, q_reg[rva_pkg::NUM_BITS-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (step)
        begin
            q_reg   <= {q_reg[rva_pkg::NUM_BITS-2:0], fits};
            rem_reg <= fits ? rem_sub[rva_pkg::DEN_BITS-1:0]
                            : rem_shift[rva_pkg::DEN_BITS-1:0];
        end
    end

    assign quotient = q_reg;

endmodule

// ===== hw/rtl/rva_datapath.sv =====
// Datapath: sample square, power-sum update, numerator and divisor products,
// two dividers and the output register. Depends on rva_pkg and rva_div.
module rva_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  rva_pkg::rva_cmd_t              ctl,
    output rva_pkg::rva_stat_t             sts,
    input  logic [rva_pkg::CMD_W-1:0]      cmd,
    input  logic [rva_pkg::SAMPLE_W-1:0]   sample,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [rva_pkg::STATUS_W-1:0]   status,
    output logic [rva_pkg::COUNT_BITS-1:0] count,
    output logic [rva_pkg::BIASED_BITS-1:0]   biased_variance,
    output logic [rva_pkg::UNBIASED_BITS-1:0] unbiased_variance
);

    localparam int SB = rva_pkg::SUM_BITS;
    localparam int QB = rva_pkg::SQ_BITS;
    localparam int NB = rva_pkg::NUM_BITS;

    // request capture
    logic [rva_pkg::CMD_W-1:0]              cmd_reg;
    logic signed [rva_pkg::SAMPLE_BITS-1:0] x_reg;
    logic [rva_pkg::SQR_BITS-1:0]           sq_reg;

    // accumulator state
    logic [rva_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic signed [SB-1:0]           sum_reg, sum_next;
    logic [QB-1:0]                  sqsum_reg, sqsum_next;
    logic [rva_pkg::STATUS_W-1:0]   stat_reg, stat_next;

    // products and division setup
    logic [NB-1:0]                  nsq_reg;
    logic [NB-1:0]                  s1sq_reg;
    logic [rva_pkg::DEN_BITS-1:0]   denb_reg, denu_reg;
    logic                           var_en_reg;
    logic                           res_en_reg;

    // output register
    logic                              out_valid_reg;
    logic [rva_pkg::STATUS_W-1:0]      status_out_reg;
    logic [rva_pkg::COUNT_BITS-1:0]    count_out_reg;
    logic [rva_pkg::BIASED_BITS-1:0]   biased_reg;
    logic [rva_pkg::UNBIASED_BITS-1:0] unbiased_reg;

    logic signed [2*rva_pkg::SAMPLE_BITS-1:0] sq_full;
    logic signed [SB:0]             sum_add, sum_sub;
    logic [QB:0]                    sq_add, sq_sub;
    logic signed [SB-1:0]           sum_add_sat, sum_sub_sat;
    logic [NB-1:0]                  nsq_full;
    logic signed [2*SB-1:0]         s1sq_full;
    logic [rva_pkg::COUNT_BITS-1:0] count_m1;
    logic [rva_pkg::DEN_BITS-1:0]   denb_full, denu_full;
    logic signed [NB:0]             num_diff;
    logic                           num_go;
    logic [NB-1:0]                  qb, qu;
    logic [rva_pkg::BIASED_BITS-1:0]   biased_sat;
    logic [rva_pkg::UNBIASED_BITS-1:0] unbiased_sat;

    localparam logic signed [SB-1:0] SUM_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SUM_MIN = {1'b1, {(SB-1){1'b0}}};

    assign sq_full = x_reg * x_reg;

    assign sum_add = {sum_reg[SB-1], sum_reg}
                   + {{(SB+1-rva_pkg::SAMPLE_BITS){x_reg[rva_pkg::SAMPLE_BITS-1]}}, x_reg};
    assign sum_sub = {sum_reg[SB-1], sum_reg}
                   - {{(SB+1-rva_pkg::SAMPLE_BITS){x_reg[rva_pkg::SAMPLE_BITS-1]}}, x_reg};
    assign sq_add  = {1'b0, sqsum_reg} + {{(QB+1-rva_pkg::SQR_BITS){1'b0}}, sq_reg};
    assign sq_sub  = {1'b0, sqsum_reg} - {{(QB+1-rva_pkg::SQR_BITS){1'b0}}, sq_reg};

    // saturate when the two top bits disagree
    assign sum_add_sat = (sum_add[SB] != sum_add[SB-1])
                       ? (sum_add[SB] ? SUM_MIN : SUM_MAX) : sum_add[SB-1:0];
    assign sum_sub_sat = (sum_sub[SB] != sum_sub[SB-1])
                       ? (sum_sub[SB] ? SUM_MIN : SUM_MAX) : sum_sub[SB-1:0];

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sqsum_next = sqsum_reg;
        stat_next  = rva_pkg::STAT_DONE;
        unique case (cmd_reg)
            rva_pkg::CMD_ADD:
            begin
                if (&count_reg)
                begin
                    stat_next = rva_pkg::STAT_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_add_sat;
                    sqsum_next = sq_add[QB] ? {QB{1'b1}} : sq_add[QB-1:0];
                end
            end
            rva_pkg::CMD_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    stat_next = rva_pkg::STAT_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    // square sum would go negative: both sums restart
                    if (sq_sub[QB])
                    begin
                        sum_next   = '0;
                        sqsum_next = '0;
                    end
                    else
                    begin
                        sum_next   = sum_sub_sat;
                        sqsum_next = sq_sub[QB-1:0];
                    end
                end
            end
            rva_pkg::CMD_CLEAR:
            begin
                count_next = '0;
                sum_next   = '0;
                sqsum_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign nsq_full  = count_reg * sqsum_reg;
    assign s1sq_full = sum_reg * sum_reg;
    assign count_m1  = count_reg - 1'b1;
    assign denb_full = count_reg * count_reg;
    assign denu_full = count_reg * count_m1;

    assign num_diff = $signed({1'b0, nsq_reg}) - $signed({1'b0, s1sq_reg});
    assign num_go   = var_en_reg && !num_diff[NB] && (num_diff != '0);

    rva_div u_div_biased
    (
        .clk      (clk),
        .load     (ctl.do_prep),
        .step     (ctl.do_step),
        .dividend (num_diff[NB-1:0]),
        .divisor  (denb_reg),
        .quotient (qb)
    );

    rva_div u_div_unbiased
    (
        .clk      (clk),
        .load     (ctl.do_prep),
        .step     (ctl.do_step),
        .dividend (num_diff[NB-1:0]),
        .divisor  (denu_reg),
        .quotient (qu)
    );

    assign biased_sat   = (|qb[NB-1:rva_pkg::BIASED_BITS])
                        ? {rva_pkg::BIASED_BITS{1'b1}} : qb[rva_pkg::BIASED_BITS-1:0];
    assign unbiased_sat = (|qu[NB-1:rva_pkg::UNBIASED_BITS])
                        ? {rva_pkg::UNBIASED_BITS{1'b1}} : qu[rva_pkg::UNBIASED_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.do_update)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                sqsum_reg <= sqsum_next;
            end
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg <= cmd;
            x_reg   <= sample[rva_pkg::SAMPLE_BITS-1:0];
        end
        if (ctl.do_square)
        begin
            sq_reg <= sq_full[rva_pkg::SQR_BITS-1:0];
        end
        if (ctl.do_update)
        begin
            stat_reg <= stat_next;
        end
        if (ctl.do_mult)
        begin
            nsq_reg    <= nsq_full;
            s1sq_reg   <= s1sq_full[NB-1:0];
            denb_reg   <= denb_full;
            denu_reg   <= denu_full;
            var_en_reg <= (count_reg > rva_pkg::COUNT_BITS'(1));
        end
        if (ctl.do_prep)
        begin
            res_en_reg <= num_go;
        end
        if (ctl.load_out)
        begin
            status_out_reg <= stat_reg;
            count_out_reg  <= count_reg;
            biased_reg     <= res_en_reg ? biased_sat : '0;
            unbiased_reg   <= res_en_reg ? unbiased_sat : '0;
        end
    end

    assign sts.out_free      = !out_valid_reg || !out_stall;
    assign out_valid         = out_valid_reg;
    assign status            = status_out_reg;
    assign count             = count_out_reg;
    assign biased_variance   = biased_reg;
    assign unbiased_variance = unbiased_reg;

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load_out && out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

    // population variance never exceeds sample variance
    a_biased_le_unbiased: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({1'b0, biased_reg} <= unbiased_reg))
        else $error("biased variance above unbiased variance");

    // a clear leaves empty sums behind
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.do_update && cmd_reg == rva_pkg::CMD_CLEAR)
        |=> (count_reg == '0 && sum_reg == '0 && sqsum_reg == '0))
        else $error("clear left nonzero state");

endmodule

// ===== hw/rtl/rva_ctrl.sv =====
// Controller: sequences capture, update, products and the serial divide.
// Depends on rva_pkg.
module rva_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rva_pkg::rva_stat_t sts,
    output rva_pkg::rva_cmd_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_UPDATE,
        S_MULT,
        S_PREP,
        S_DIVIDE,
        S_EMIT
    } state_t;

    localparam logic [rva_pkg::DIV_CNT_BITS-1:0] LAST_STEP =
        rva_pkg::DIV_CNT_BITS'(rva_pkg::NUM_BITS - 1);

    state_t                            state_reg;
    logic [rva_pkg::DIV_CNT_BITS-1:0]  cnt_reg;
    logic                              accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE: state_reg <= S_UPDATE;
                S_UPDATE: state_reg <= S_MULT;
                S_MULT:   state_reg <= S_PREP;
                S_PREP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIVIDE;
                end
                S_DIVIDE:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        ctl.load_in   = accept;
        ctl.do_square = (state_reg == S_SQUARE);
        ctl.do_update = (state_reg == S_UPDATE);
        ctl.do_mult   = (state_reg == S_MULT);
        ctl.do_prep   = (state_reg == S_PREP);
        ctl.do_step   = (state_reg == S_DIVIDE);
        ctl.load_out  = (state_reg == S_EMIT) && sts.out_free;
    end

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE && cnt_reg == LAST_STEP) |=> (state_reg == S_EMIT))
        else $error("divide did not end after last step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SQUARE && in_stall))
        else $error("accepted request did not start processing");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE) |-> (cnt_reg <= LAST_STEP))
        else $error("divide step counter out of range");

endmodule

// ===== hw/rtl/running_variance_accumulator.sv =====
// Running variance accumulator: count, sum and sum of squares of samples.
// A request passes 4 setup stages (square, update, multiply, prep), 55 divide
// steps and 1 output load, which waits while a stalled result is held; one
// request in flight, the next taken only back in idle; bit-serial 55-bit divide.
// Reset (rst_n, async low) empties the sums and drops any pending result.
module running_variance_accumulator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rva_pkg::CMD_W-1:0]           cmd,
    input  logic [rva_pkg::SAMPLE_W-1:0]        sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rva_pkg::STATUS_W-1:0]        status,
    output logic [rva_pkg::COUNT_BITS-1:0]      count,
    output logic [rva_pkg::BIASED_BITS-1:0]     biased_variance,
    output logic [rva_pkg::UNBIASED_BITS-1:0]   unbiased_variance
);

    rva_pkg::rva_cmd_t  ctl;
    rva_pkg::rva_stat_t sts;

    rva_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    rva_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .sts               (sts),
        .cmd               (cmd),
        .sample            (sample),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .status            (status),
        .count             (count),
        .biased_variance   (biased_variance),
        .unbiased_variance (unbiased_variance)
    );

endmodule
